// File: rtl/core/sse_pkg.sv
// sse_pkg: shared constants for the selection sort engine
// no dependencies

package sse_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

endpackage

// File: rtl/core/sse_mem.sv
// sse_mem: element store, one write port and one read port, registered read data
// depends on sse_pkg

module sse_mem
    import sse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS)
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sse_ctrl.sv
// sse_ctrl: collect, selection sort and emit sequencer around the element store
// depends on sse_pkg; drives the ports of sse_mem

module sse_ctrl
    import sse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS),
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow,
    output logic                     mem_we,
    output logic [AW-1:0]            mem_waddr,
    output logic signed [DATA_W-1:0] mem_wdata,
    output logic                     mem_re,
    output logic [AW-1:0]            mem_raddr,
    input  logic signed [DATA_W-1:0] mem_rdata
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    typedef enum logic [2:0] {
        S_COLLECT,
        S_SCAN,
        S_SWAP_POS,
        S_SWAP_BEST,
        S_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [CNT_W-1:0]         issue_reg, issue_next;
    logic                     rvalid_reg, rvalid_next;
    logic [AW-1:0]            ridx_reg, ridx_next;
    logic                     rlast_reg, rlast_next;
    logic [AW-1:0]            best_idx_reg, best_idx_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic signed [DATA_W-1:0] pos_val_reg, pos_val_next;

    logic                     accept;
    logic                     has_room;
    logic [CNT_W-1:0]         count_upd;
    logic [CNT_W-1:0]         pos_ext;

    assign accept   = start && (state_reg == S_COLLECT);
    assign has_room = count_reg < MAX_CNT;
    assign count_upd = has_room ? count_reg + CNT_W'(1) : count_reg;
    assign pos_ext  = CNT_W'(pos_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        issue_next    = issue_reg;
        rvalid_next   = 1'b0;
        ridx_next     = ridx_reg;
        rlast_next    = rlast_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        pos_val_next  = pos_val_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = value;
        mem_re        = 1'b0;
        mem_raddr     = issue_reg[AW-1:0];

        // read issue shared by scan and emit
        if ((state_reg == S_SCAN || state_reg == S_EMIT) && issue_reg < count_reg)
        begin
            mem_re      = 1'b1;
            rvalid_next = 1'b1;
            ridx_next   = issue_reg[AW-1:0];
            rlast_next  = (issue_reg == count_reg - CNT_W'(1));
            issue_next  = issue_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_COLLECT:
            begin
                if (accept)
                begin
                    if (has_room)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_upd;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        pos_next   = '0;
                        issue_next = '0;
                        state_next = (count_upd < CNT_W'(2)) ? S_EMIT : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rvalid_reg)
                begin
                    if (ridx_reg == pos_reg)
                    begin
                        best_val_next = mem_rdata;
                        best_idx_next = ridx_reg;
                        pos_val_next  = mem_rdata;
                    end
                    else if (mem_rdata < best_val_reg)
                    begin
                        best_val_next = mem_rdata;
                        best_idx_next = ridx_reg;
                    end
                    if (rlast_reg)
                    begin
                        state_next = S_SWAP_POS;
                    end
                end
            end
            S_SWAP_POS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = best_val_reg;
                state_next = S_SWAP_BEST;
            end
            S_SWAP_BEST:
            begin
                mem_we    = 1'b1;
                mem_waddr = best_idx_reg;
                mem_wdata = pos_val_reg;
                if (pos_ext + CNT_W'(2) < count_reg)
                begin
                    pos_next   = pos_reg + AW'(1);
                    issue_next = pos_ext + CNT_W'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    issue_next = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (rvalid_reg && rlast_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_COLLECT;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            pos_reg    <= '0;
            issue_reg  <= '0;
            rvalid_reg <= 1'b0;
            ridx_reg   <= '0;
            rlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            pos_reg    <= pos_next;
            issue_reg  <= issue_next;
            rvalid_reg <= rvalid_next;
            ridx_reg   <= ridx_next;
            rlast_reg  <= rlast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        pos_val_reg  <= pos_val_next;
    end

    assign busy         = (state_reg != S_COLLECT);
    assign out_valid    = (state_reg == S_EMIT) && rvalid_reg;
    assign sorted_value = mem_rdata;
    assign last_out     = rlast_reg;
    assign overflow     = ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("element count above store depth");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_EMIT) |-> !mem_we)
        else $error("store written while reading a batch");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (CNT_W'(ridx_reg) < count_reg))
        else $error("read beyond stored elements");

    a_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_out) |=> (!busy && count_reg == '0 && !overflow))
        else $error("batch not closed after final transfer");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP_POS) |=> (state_reg == S_SWAP_BEST))
        else $error("swap split");
`endif

endmodule

// File: rtl/core/selection_sort_engine_top.sv
// selection_sort_engine_top: collects signed words, sorts them in place, emits them ascending
// depends on sse_pkg, sse_mem, sse_ctrl
//
// usage:
//   input: a transfer happens on a rising edge with start high and busy low; value and last
//   are sampled there. each value goes into the store while it has room; a value that
//   arrives with the store full is dropped and flags the batch as overflowed.
//   the transfer with last high ends the batch and raises busy.
//   sort: one pass per position streams the remaining entries out of the single-port
//   read side of the store (one entry a cycle) to find the minimum, then the SWAP_POS and
//   SWAP_BEST states write the swap back.
//   output: n transfers in ascending order on consecutive cycles, each marked by out_valid
//   for one cycle, with last_out on the final one and overflow on all of a dropped batch.
//   busy falls the cycle after the final output; the receiver cannot stall the outputs.
//   collection takes one item per cycle.
//   reset: counts and the overflow flag clear, the block waits for input; store contents
//   are not cleared since only entries written in the current batch are read.

module selection_sort_engine_top
    import sse_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    sse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    sse_mem #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

// File: tb/selection_sort_engine_top_tb.sv
// selection_sort_engine_top_tb: self-checking bench for the selection sort engine
// drives batches of signed words through start/busy, predicts the ascending output
// depends on sse_pkg and selection_sort_engine_top

module selection_sort_engine_top_tb;
    import sse_pkg::*;

    localparam int DEPTH       = MAX_ITEMS_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int TARGET      = 270;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        bit                       last;
        bit                       drain;
    } element_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        bit                       last;
        bit                       ovf;
    } sorted_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     out_valid;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;

    element_t                 pending[$];
    sorted_word_t             sorted_due[$];
    logic signed [DATA_W-1:0] batch_words[DEPTH];
    int                       batch_count;
    bit                       batch_dropped;
    bit                       took;
    int                       sent;
    int                       stall_cycles;
    int                       errors;
    int                       queued;
    element_t                 head;

    selection_sort_engine_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_error(input string what, input longint got, input longint want);
        errors++;
        $display("sort check failed: %s got %0d want %0d", what, got, want);
    endtask

    // store one word, and on the final word of a batch sort and queue the results
    task automatic absorb_element(input logic signed [DATA_W-1:0] v, input bit l);
        int                       best;
        logic signed [DATA_W-1:0] tmp;
        sorted_word_t             w;
        if (batch_count < DEPTH)
        begin
            batch_words[batch_count] = v;
            batch_count++;
        end
        else
            batch_dropped = 1'b1;
        if (!l)
            return;
        for (int p = 0; p + 1 < batch_count; p++)
        begin
            best = p;
            for (int s = p + 1; s < batch_count; s++)
                if (batch_words[s] < batch_words[best])
                    best = s;
            tmp               = batch_words[best];
            batch_words[best] = batch_words[p];
            batch_words[p]    = tmp;
        end
        for (int k = 0; k < batch_count; k++)
        begin
            w.value = batch_words[k];
            w.last  = (k == batch_count - 1);
            w.ovf   = batch_dropped;
            sorted_due.push_back(w);
        end
        batch_count   = 0;
        batch_dropped = 1'b0;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (pending.size() == 0)
                start <= 1'b0;
            else if (pending[0].drain && (sorted_due.size() != 0 || busy))
                start <= 1'b0;
            else if (!(sent >= 120 && sent < 200) && $urandom_range(99) < 19)
                start <= 1'b0;
            else
            begin
                head = pending.pop_front();
                start <= 1'b1;
                value <= head.value;
                last  <= head.last;
                sent++;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sorted_word_t w;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
                absorb_element(value, last);
            if (out_valid)
            begin
                if (sorted_due.size() == 0)
                    report_error("unexpected result, sorted_value", sorted_value, 0);
                else
                begin
                    w = sorted_due.pop_front();
                    if (sorted_value !== w.value)
                        report_error("sorted_value", sorted_value, w.value);
                    if (last_out !== w.last)
                        report_error("last_out", last_out, w.last);
                    if (overflow !== w.ovf)
                        report_error("overflow", overflow, w.ovf);
                end
            end
            if (took || out_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("selection_sort_engine_top: mismatch");
        $finish;
    end

    task automatic push_element(input logic signed [DATA_W-1:0] v, input bit l,
                                input bit d = 1'b0);
        element_t e;
        e.value = v;
        e.last  = l;
        e.drain = d;
        pending.push_back(e);
        queued++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int t;
        case ($urandom_range(7))
            0:
            begin
                t = $urandom_range(8);
                return t - 4;
            end
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic random_batch(input int n, input bit d);
        for (int i = 0; i < n; i++)
            push_element(pick_value(), i == n - 1, d && i == 0);
    endtask

    initial
    begin
        int nb;
        start         = 1'b0;
        value         = '0;
        last          = 1'b0;
        took          = 1'b0;
        sent          = 0;
        stall_cycles  = 0;
        errors        = 0;
        queued        = 0;
        batch_count   = 0;
        batch_dropped = 1'b0;

        // single-word batches at the extremes
        push_element(32'sh7FFF_FFFF, 1'b1);
        push_element(32'sh8000_0000, 1'b1);
        // mixed extremes
        push_element(0, 1'b0);
        push_element(-1, 1'b0);
        push_element(32'sh7FFF_FFFF, 1'b0);
        push_element(32'sh8000_0000, 1'b0);
        push_element(1, 1'b0);
        push_element(-2, 1'b1);
        // equal values
        push_element(5, 1'b0);
        push_element(5, 1'b0);
        push_element(-5, 1'b0);
        push_element(5, 1'b1);
        push_element(32'sh8000_0000, 1'b0);
        push_element(32'sh8000_0000, 1'b1);
        // already ascending, then descending
        push_element(1, 1'b0);
        push_element(2, 1'b0);
        push_element(3, 1'b1);
        push_element(3, 1'b0);
        push_element(2, 1'b0);
        push_element(1, 1'b1);

        nb = 0;
        while (queued < TARGET)
        begin
            if (nb == 3)
                random_batch(DEPTH, 1'b0);
            else if (nb == 9)
                random_batch(DEPTH + 2, 1'b1);
            else
                random_batch($urandom_range(1, 12), nb == 0 || $urandom_range(9) == 0);
            nb++;
        end

        wait (pending.size() == 0 && !start);
        wait (sorted_due.size() == 0 && !busy);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("selection_sort_engine_top: match");
        else
            $display("selection_sort_engine_top: mismatch");
        $finish;
    end

endmodule
